FILE: design/assert_macros.svh
// Assertion macros shared by the tick timer expiry table RTL.
// Each check is clocked on the rising edge and is switched off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define ASSERT_SYNC(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Expression must never be true out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_SYNC(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

FILE: design/ttet_pkg.sv
// Package for the tick timer expiry table: sizes, item structs, command codes,
// controller/datapath interface structs and the saturating add. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttet_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int COUNT_BITS = 48;

  localparam int SLOT_W  = 4;
  localparam int WAIT_W  = 32;
  localparam int TAG_W   = 16;
  localparam int SCALE_W = 16;
  localparam int PROD_W  = SCALE_W + WAIT_W;
  localparam int SUM_W   = ((COUNT_BITS > PROD_W) ? COUNT_BITS : PROD_W) + 1;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);

  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_INSTALL = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] timer_slot;
    logic [WAIT_W-1:0] wait_ms;
    logic [TAG_W-1:0]  context_tag;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] fired_slot;
    logic [TAG_W-1:0]  fired_context;
    logic              last_of_run;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture_install;
    logic tick_start;
    logic install_write;
    logic scan_step;
    logic flush;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
    logic flush_done;
  } dp_stat_t;

  function automatic count_t sat_add(count_t a, logic [PROD_W-1:0] b);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(a) + SUM_W'(b);
    if (sum > SUM_W'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return COUNT_BITS'(sum);
  endfunction

endpackage

`default_nettype wire

FILE: design/ttet_ctrl.sv
// Controller of the tick timer expiry table: sequences install, scan and flush.
// Depends on ttet_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttet_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_ready,
  input  ttet_pkg::dp_stat_t stat_i,
  output ttet_pkg::dp_cmd_t  cmd_o
);
  import ttet_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSTALL,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   accept;

  assign accept   = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  always_comb begin
    cmd_o.capture_install = accept && (in_cmd == CMD_INSTALL);
    cmd_o.tick_start      = accept && (in_cmd == CMD_TICK);
    cmd_o.install_write   = (state_r == S_INSTALL);
    cmd_o.scan_step       = (state_r == S_SCAN);
    cmd_o.flush           = (state_r == S_FLUSH);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_cmd == CMD_INSTALL) ? S_INSTALL : S_SCAN;
        end
      end
      S_INSTALL: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat_i.flush_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  `ASSERT_SYNC(a_ready_only_idle, clk, rst_n, in_ready_r |-> (state_r == S_IDLE))
  `ASSERT_SYNC(a_install_enters, clk, rst_n, cmd_o.capture_install |=> (state_r == S_INSTALL))
  `ASSERT_SYNC(a_install_one_cycle, clk, rst_n, (state_r == S_INSTALL) |=> (state_r == S_IDLE))

endmodule

`default_nettype wire

FILE: design/ttet_datapath.sv
// Datapath of the tick timer expiry table: counter, slot memories, active bits,
// scan pipeline, pending result and output register. Depends on ttet_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ttet_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ttet_pkg::dp_cmd_t             cmd_i,
  output ttet_pkg::dp_stat_t            stat_o,
  input  logic                          cfg_wr_en,
  input  logic [ttet_pkg::SCALE_W-1:0]  cfg_wr_data,
  input  ttet_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ttet_pkg::out_item_t           out_data
);
  import ttet_pkg::*;

  logic [SCALE_W-1:0]    scale_r;
  count_t                count_r;
  logic [PROD_W-1:0]     prod_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [TAG_W-1:0]      tag_r;
  logic [NUM_TIMERS-1:0] active_r;

  count_t                expiry_mem [NUM_TIMERS];
  logic [TAG_W-1:0]      ctx_mem    [NUM_TIMERS];

  logic [CNT_W-1:0]      rd_idx_r;
  logic                  chk_v_r;
  logic [IDX_W-1:0]      chk_idx_r;
  count_t                exp_rd_r;
  logic [TAG_W-1:0]      ctx_rd_r;

  logic                  pend_v_r;
  out_item_t             pend_r;
  logic                  out_v_r;
  out_item_t             out_r;

  logic                  slot_ok;
  logic [IDX_W-1:0]      wr_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_more;
  logic                  out_free;
  logic                  hit;
  logic                  stall;
  logic                  advance;
  logic                  commit;
  logic                  push_mid;
  logic                  push_last;

  assign slot_ok   = (int'(slot_r) < NUM_TIMERS);
  assign wr_idx    = IDX_W'(slot_r);
  assign rd_idx    = rd_idx_r[IDX_W-1:0];
  assign rd_more   = (rd_idx_r < CNT_W'(NUM_TIMERS));
  assign out_free  = !out_v_r || out_ready;

  assign hit       = cmd_i.scan_step && chk_v_r && active_r[chk_idx_r] && (exp_rd_r <= count_r);
  assign stall     = hit && pend_v_r && !out_free;
  assign advance   = cmd_i.scan_step && !stall;
  assign commit    = hit && !stall;
  assign push_mid  = commit && pend_v_r;
  assign push_last = cmd_i.flush && pend_v_r && out_free;

  assign stat_o.scan_done  = !chk_v_r && !rd_more;
  assign stat_o.flush_done = !pend_v_r || out_free;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Slot memories: one write port for installs, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (cmd_i.install_write && slot_ok) begin
      expiry_mem[wr_idx] <= sat_add(count_r, prod_r);
      ctx_mem[wr_idx]    <= tag_r;
    end
    if (advance && rd_more) begin
      exp_rd_r  <= expiry_mem[rd_idx];
      ctx_rd_r  <= ctx_mem[rd_idx];
      chk_idx_r <= rd_idx;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.capture_install) begin
      prod_r <= PROD_W'(scale_r) * PROD_W'(in_data.wait_ms);
      slot_r <= in_data.timer_slot;
      tag_r  <= in_data.context_tag;
    end
    if (commit) begin
      pend_r.fired_slot    <= SLOT_W'(chk_idx_r);
      pend_r.fired_context <= ctx_rd_r;
      pend_r.last_of_run   <= 1'b0;
    end
    if (push_mid) begin
      out_r <= pend_r;
    end else if (push_last) begin
      out_r <= '{fired_slot: pend_r.fired_slot, fired_context: pend_r.fired_context,
                 last_of_run: 1'b1};
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RESET;
      count_r  <= '0;
      active_r <= '0;
      rd_idx_r <= '0;
      chk_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      if (cmd_i.tick_start) begin
        count_r  <= sat_add(count_r, PROD_W'(scale_r));
        rd_idx_r <= '0;
        chk_v_r  <= 1'b0;
      end else if (advance) begin
        chk_v_r <= rd_more;
        if (rd_more) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
      end
      if (cmd_i.install_write && slot_ok) begin
        active_r[wr_idx] <= 1'b1;
      end
      if (commit) begin
        active_r[chk_idx_r] <= 1'b0;
      end
      if (commit) begin
        pend_v_r <= 1'b1;
      end else if (push_last) begin
        pend_v_r <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  `ASSERT_NEVER(a_scan_index_bound, clk, rst_n, rd_idx_r > CNT_W'(NUM_TIMERS))
  `ASSERT_SYNC(a_fired_slot_freed, clk, rst_n, commit |=> !active_r[$past(chk_idx_r)])
  `ASSERT_SYNC(a_mid_result_has_successor, clk, rst_n, push_mid |=> pend_v_r)

endmodule

`default_nettype wire

FILE: design/tick_timer_expiry_table.sv
// Top level of the tick timer expiry table: joins controller and datapath.
// Depends on ttet_pkg, ttet_ctrl, ttet_datapath.
//
//   Channel   Direction  Handshake              Payload
//   in_       in         in_valid / in_ready    in_data  (ttet_pkg::in_item_t)
//   out_      out        out_valid / out_ready  out_data (ttet_pkg::out_item_t)
//   cfg_      in         cfg_wr_en              cfg_wr_data (tick_scale)
//
// In an install transaction the accept cycle forms scale times wait in the
// multiplier, the next cycle adds it to the count and writes the slot memories.
// A tick transaction scans one slot a cycle through the single read port of the slot
// memories when the output side keeps up. A stalled output holds the scan when a
// further expiry is found while the pending and output registers are both full, and
// holds the flush cycle while the last result waits on a full output register.
// Reset (rst_n low, synchronous) clears the counter, all active bits and the result
// valid bits and sets tick_scale to one; slot memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module tick_timer_expiry_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ttet_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ttet_pkg::out_item_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [ttet_pkg::SCALE_W-1:0]  cfg_wr_data
);
  import ttet_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Controller: takes one transaction at a time and steps the datapath through it
  ttet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd)
  );

  // Datapath: counter, slot table, scan pipeline and the output register that
  // parts the result side from the scan
  ttet_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

FILE: bench/tb_tick_timer_expiry_table.sv
// Self-checking bench for tick_timer_expiry_table: directed plan, random phases
// over several tick_scale settings and a back-to-back tick run at the top scale.
// Depends on ttet_pkg and the tick_timer_expiry_table RTL only.
`timescale 1ns / 1ps

module tb_tick_timer_expiry_table;
  import ttet_pkg::*;

  // Directed plan row: one input transaction, and where the answer is obvious
  // the expiries typed in by hand (at most two per tick in this plan).
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    logic [1:0] n_fired;
    out_item_t first;
    out_item_t second;
  } plan_row_t;

  localparam int N_PLAN = 17;
  localparam int RANDOM_PHASE_ITEMS = 32;
  localparam int TOP_SCALE_TICKS = 12;
  localparam int SETTLE_CYCLES = 40;

  // Counts up from reset with tick_scale at one; comments give the count after
  // each tick and the expiry armed by each install.
  localparam plan_row_t PLAN [N_PLAN] = '{
    // tick with every ignored field at its top value: count 1, table empty
    '{'{CMD_TICK, 4'hF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, 2'd0, '0, '0},
    // wait of zero: expiry 1, already reached
    '{'{CMD_INSTALL, 4'h0, 32'h0, 16'hAAAA}, 1'b1, 2'd0, '0, '0},
    // count 2: slot 0 fires alone
    '{'{CMD_TICK, 4'h0, 32'h0, 16'h0}, 1'b1, 2'd1, '{4'h0, 16'hAAAA, 1'b1}, '0},
    '{'{CMD_INSTALL, 4'hF, 32'h1, 16'hFFFF}, 1'b1, 2'd0, '0, '0},
    '{'{CMD_INSTALL, 4'h3, 32'h2, 16'h1234}, 1'b1, 2'd0, '0, '0},
    // overwrite the armed slot 3: expiry 3, new tag
    '{'{CMD_INSTALL, 4'h3, 32'h1, 16'h5678}, 1'b1, 2'd0, '0, '0},
    // count 3: two expiries, slot order, last one marked
    '{'{CMD_TICK, 4'h5, 32'h0, 16'h0}, 1'b1, 2'd2,
      '{4'h3, 16'h5678, 1'b0}, '{4'hF, 16'hFFFF, 1'b1}},
    // longest wait, far in the future
    '{'{CMD_INSTALL, 4'h7, 32'hFFFF_FFFF, 16'h0000}, 1'b1, 2'd0, '0, '0},
    // count 4: nothing due
    '{'{CMD_TICK, 4'h0, 32'h0, 16'h0}, 1'b1, 2'd0, '0, '0},
    '{'{CMD_INSTALL, 4'h8, 32'h0, 16'h0001}, 1'b1, 2'd0, '0, '0},
    // count 5: slot 8 fires, slot 7 stays armed
    '{'{CMD_TICK, 4'hA, 32'h5555_5555, 16'h5555}, 1'b1, 2'd1,
      '{4'h8, 16'h0001, 1'b1}, '0},
    '{'{CMD_INSTALL, 4'h4, 32'h3, 16'h5555}, 1'b0, 2'd0, '0, '0},
    '{'{CMD_INSTALL, 4'hC, 32'h2, 16'h3C3C}, 1'b0, 2'd0, '0, '0},
    '{'{CMD_TICK, 4'h0, 32'h0, 16'h0}, 1'b1, 2'd0, '0, '0},
    '{'{CMD_TICK, 4'h0, 32'hAAAA_AAAA, 16'hAAAA}, 1'b0, 2'd0, '0, '0},
    '{'{CMD_TICK, 4'h0, 32'h0, 16'h0}, 1'b0, 2'd0, '0, '0},
    '{'{CMD_INSTALL, 4'h0, 32'h8000_0000, 16'h8000}, 1'b0, 2'd0, '0, '0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_wr_en = 1'b0;
  logic [SCALE_W-1:0]  cfg_wr_data = '0;

  // Predicted state of the timer table
  logic [SCALE_W-1:0]  model_scale;
  count_t              model_count;
  logic                model_armed [NUM_TIMERS];
  count_t              model_expiry [NUM_TIMERS];
  logic [TAG_W-1:0]    model_tag [NUM_TIMERS];

  out_item_t           fires_due [$];
  int                  fail_count = 0;
  int                  items_in = 0;
  int                  fires_seen = 0;
  bit                  steady = 1'b0;
  int                  ready_hold = 0;

  tick_timer_expiry_table uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Clamp a + b at the counter maximum
  function automatic count_t clamp_add(count_t a, count_t b);
    logic [COUNT_BITS:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[COUNT_BITS] ? COUNT_MAX : total[COUNT_BITS-1:0];
  endfunction

  // Advance the predicted table by one accepted transaction; queue the
  // expiries it causes unless the plan has typed them in already.
  task automatic advance_timer_table(input in_item_t it, input bit queue_fires);
    count_t    span;
    out_item_t fire;
    int        last_idx;
    if (it.cmd == CMD_INSTALL) begin
      span = count_t'(model_scale) * count_t'(it.wait_ms);
      model_expiry[it.timer_slot] = clamp_add(model_count, span);
      model_tag[it.timer_slot]    = it.context_tag;
      model_armed[it.timer_slot]  = 1'b1;
    end else begin
      model_count = clamp_add(model_count, count_t'(model_scale));
      last_idx = -1;
      for (int s = 0; s < NUM_TIMERS; s++) begin
        if (model_armed[s] && model_expiry[s] <= model_count) last_idx = s;
      end
      for (int s = 0; s < NUM_TIMERS; s++) begin
        if (model_armed[s] && model_expiry[s] <= model_count) begin
          model_armed[s]     = 1'b0;
          fire.fired_slot    = SLOT_W'(s);
          fire.fired_context = model_tag[s];
          fire.last_of_run   = (s == last_idx);
          if (queue_fires) fires_due.push_back(fire);
        end
      end
    end
  endtask

  // Mostly short gaps, now and then a long one; none in a steady stretch
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transaction and hold it until the block takes it. Called and
  // returns just after a rising edge.
  task automatic offer(input in_item_t it, input bit queue_fires);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_in++;
    advance_timer_table(it, queue_fires);
  endtask

  // Drop valid and wait until every predicted expiry has been seen
  task automatic drain();
    in_valid <= 1'b0;
    wait (fires_due.size() == 0);
    @(posedge clk);
  endtask

  // Write tick_scale only with the block idle: drained, then past the longest
  // scan, since a tick with no expiry gives no sign of finishing.
  task automatic set_tick_scale(input logic [SCALE_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_scale = value;
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int       roll;
    it.timer_slot  = SLOT_W'($urandom_range(0, NUM_TIMERS - 1));
    it.context_tag = TAG_W'($urandom_range(0, 65535));
    it.wait_ms     = $urandom;
    if ($urandom_range(0, 99) < 40) begin
      it.cmd = CMD_TICK;
    end else begin
      it.cmd = CMD_INSTALL;
      // Keep most waits within a few ticks so timers actually fire
      roll = $urandom_range(0, 99);
      if (roll < 75) it.wait_ms = $urandom_range(0, 4);
      else if (roll < 90) it.wait_ms = $urandom_range(5, 60);
    end
    return it;
  endfunction

  // Arm every slot at once, then tick so the whole table fires in one run
  task automatic arm_whole_table();
    in_item_t it;
    for (int s = 0; s < NUM_TIMERS; s++) begin
      it.cmd         = CMD_INSTALL;
      it.timer_slot  = SLOT_W'(s);
      it.wait_ms     = $urandom_range(0, 1);
      it.context_tag = TAG_W'($urandom_range(0, 65535));
      offer(it, 1'b1);
    end
    it = random_item();
    it.cmd = CMD_TICK;
    offer(it, 1'b1);
    offer(it, 1'b1);
  endtask

  task automatic random_phase(input logic [SCALE_W-1:0] scale, input bit calm);
    int start;
    int roll;
    set_tick_scale(scale);
    steady = calm;
    start = items_in;
    while (items_in - start < RANDOM_PHASE_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) arm_whole_table();
      else if (roll < 9) drain();
      else offer(random_item(), 1'b1);
    end
    steady = 1'b0;
  endtask

  // Result side: random stalls, mostly short, a few long, none when steady
  always @(posedge clk) begin
    if (steady) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready  <= ($urandom_range(0, 99) < 65);
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 3);
    end
  end

  // Compare each expiry leaving the block with the oldest prediction
  always @(posedge clk) begin : check_fires
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      fires_seen++;
      if (fires_due.size() == 0) begin
        $error("expiry of slot %0d with nothing expected", out_data.fired_slot);
        fail_count++;
      end else begin
        want = fires_due.pop_front();
        if (out_data.fired_slot !== want.fired_slot) begin
          $error("fired_slot: expected %0d, got %0d", want.fired_slot,
                 out_data.fired_slot);
          fail_count++;
        end
        if (out_data.fired_context !== want.fired_context) begin
          $error("fired_context: expected 0x%04h, got 0x%04h", want.fired_context,
                 out_data.fired_context);
          fail_count++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                 out_data.last_of_run);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    model_scale = SCALE_RESET;
    model_count = '0;
    for (int s = 0; s < NUM_TIMERS; s++) model_armed[s] = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan at the reset scale; typed rows carry their own answers
    for (int r = 0; r < N_PLAN; r++) begin
      offer(PLAN[r].item, !PLAN[r].typed);
      if (PLAN[r].typed && PLAN[r].n_fired > 0) fires_due.push_back(PLAN[r].first);
      if (PLAN[r].typed && PLAN[r].n_fired > 1) fires_due.push_back(PLAN[r].second);
    end

    // Random phases over the extremes of tick_scale and values between
    random_phase(SCALE_W'(0), 1'b0);
    random_phase(SCALE_W'(65535), 1'b0);
    random_phase(SCALE_W'($urandom_range(2, 65534)), 1'b0);
    random_phase(SCALE_W'($urandom_range(2, 16)), 1'b1);
    random_phase(SCALE_W'(1), 1'b0);

    // Advance the count back to back at the top scale
    set_tick_scale(SCALE_W'(65535));
    steady = 1'b1;
    it = '0;
    it.cmd = CMD_TICK;
    for (int t = 0; t < TOP_SCALE_TICKS; t++) offer(it, 1'b1);
    steady = 1'b0;

    // Longest wait must stay armed; a short wait beside it still fires
    it = '{CMD_INSTALL, 4'h5, 32'hFFFF_FFFF, 16'hBEEF};
    offer(it, 1'b1);
    it = '{CMD_INSTALL, 4'h6, 32'h0000_0001, 16'h4242};
    offer(it, 1'b1);
    it = '{CMD_TICK, 4'h0, 32'h0, 16'h0};
    offer(it, 1'b1);
    offer(it, 1'b1);

    // Zero scale: the longest wait expires at the current count
    set_tick_scale(SCALE_W'(0));
    it = '{CMD_INSTALL, 4'h9, 32'hFFFF_FFFF, 16'h0F0F};
    offer(it, 1'b1);
    it = '{CMD_TICK, 4'h0, 32'h0, 16'h0};
    offer(it, 1'b1);

    // Let the last scan finish and catch any stray expiry
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fires_due.size() != 0) begin
      $error("%0d predicted expiries never arrived", fires_due.size());
      fail_count++;
    end

    $display("Run covered %0d transactions in and %0d expiries out, with tick_scale",
             items_in, fires_seen);
    $display("at 1, 0, 65535 and random values, whole-table runs and back-to-back ticks.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/ttet_pkg.sv
design/ttet_ctrl.sv
design/ttet_datapath.sv
design/tick_timer_expiry_table.sv
bench/tb_tick_timer_expiry_table.sv
